// ----- hdl/rgbc_pkg.sv -----
// Shared types and constants for the RGB 3x3 convolution block.
// No dependencies; imported by every module under hdl/.
`timescale 1ns / 1ps

package rgbc_pkg;

  localparam int CHAN_W     = 8;
  localparam int PIX_W      = 3 * CHAN_W;
  localparam int ROW_W      = 12;
  localparam int HGT_W      = 13;
  localparam int WID_W      = 11;
  localparam int COEF_W     = 8;
  localparam int TAP_SUM_W  = CHAN_W + 2;
  localparam int PROD_W     = COEF_W + TAP_SUM_W + 1;
  localparam int ACC_W      = PROD_W + 2;
  localparam int MAX_HEIGHT = 4096;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 13;
  localparam int CHAN_MAX   = 255;

  localparam logic [WID_W-1:0]  WIDTH_RST  = 11'd640;
  localparam logic [HGT_W-1:0]  HEIGHT_RST = 13'd480;
  localparam logic [COEF_W-1:0] CORNER_RST = 8'h00;
  localparam logic [COEF_W-1:0] EDGE_RST   = 8'hFF;
  localparam logic [COEF_W-1:0] CENTRE_RST = 8'd50;

  typedef logic [CHAN_W-1:0]        chan_t;
  typedef logic [PIX_W-1:0]         pixel_t;
  typedef logic signed [COEF_W-1:0] coef_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [ACC_W-1:0]  acc_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH  = 3'd0,
    REG_IMAGE_HEIGHT = 3'd1,
    REG_CORNER_COEF  = 3'd2,
    REG_EDGE_COEF    = 3'd3,
    REG_CENTER_COEF  = 3'd4
  } reg_index_t;

  // Coefficient set handed to every channel lane
  typedef struct packed {
    coef_t corner;
    coef_t side;
    coef_t centre;
  } kernel_t;

endpackage

// ----- hdl/rgb_3x3_convolution_clamp_top.sv -----
// Top level of the streaming RGB 3x3 convolution with clamp.
// Depends on rgbc_pkg, rgbc_line_store and rgbc_lane.
//
//  port group    | direction | transfer when              | carries
//  in_*          | in        | in_valid & !in_stall       | red_in green_in blue_in frame_start
//  out_*         | out       | out_valid & !out_stall     | red/green/blue_out out_row out_col frame_end
//  cfg_*         | in        | cfg_valid & cfg_ready      | cfg_index, cfg_data
//
// One pixel per clock sustained while the output is not stalled.
// Pipeline: line store read + position, product registers in the three lanes,
// merged output register. The line store has one read and one write port.
// Reset clears position, window and stage valids; line store is not cleared.
// A stalled output holds; the input keeps flowing until every stage is full.
`timescale 1ns / 1ps

module rgb_3x3_convolution_clamp_top
  import rgbc_pkg::*;
#(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [CHAN_W-1:0]            red_in,
  input  logic [CHAN_W-1:0]            green_in,
  input  logic [CHAN_W-1:0]            blue_in,
  input  logic                         frame_start,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [CHAN_W-1:0]            red_out,
  output logic [CHAN_W-1:0]            green_out,
  output logic [CHAN_W-1:0]            blue_out,
  output logic [ROW_W-1:0]             out_row,
  output logic [$clog2(MAX_WIDTH)-1:0] out_col,
  output logic                         frame_end,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [CFG_IDX_W-1:0]         cfg_index,
  input  logic [CFG_DATA_W-1:0]        cfg_data
);

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int WCMP  = (COL_W + 2 > WID_W) ? COL_W + 2 : WID_W;

  // configuration
  logic [WID_W-1:0] image_width;
  logic [HGT_W-1:0] image_height;
  kernel_t          kernel;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width   <= WIDTH_RST;
      image_height  <= HEIGHT_RST;
      kernel.corner <= CORNER_RST;
      kernel.side   <= EDGE_RST;
      kernel.centre <= CENTRE_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_IMAGE_WIDTH:  image_width   <= cfg_data[WID_W-1:0];
        REG_IMAGE_HEIGHT: image_height  <= cfg_data[HGT_W-1:0];
        REG_CORNER_COEF:  kernel.corner <= cfg_data[COEF_W-1:0];
        REG_EDGE_COEF:    kernel.side   <= cfg_data[COEF_W-1:0];
        REG_CENTER_COEF:  kernel.centre <= cfg_data[COEF_W-1:0];
        default: ;
      endcase
    end
  end

  logic [WCMP-1:0]  w_use;
  logic [HGT_W-1:0] h_use;

  always_comb begin
    if (WCMP'(image_width) < WCMP'(3)) begin
      w_use = WCMP'(3);
    end else if (WCMP'(image_width) > WCMP'(MAX_WIDTH)) begin
      w_use = WCMP'(MAX_WIDTH);
    end else begin
      w_use = WCMP'(image_width);
    end
    if (image_height < HGT_W'(3)) begin
      h_use = HGT_W'(3);
    end else if (image_height > HGT_W'(MAX_HEIGHT)) begin
      h_use = HGT_W'(MAX_HEIGHT);
    end else begin
      h_use = image_height;
    end
  end

  // handshake across the three stages
  logic b_valid, p_valid;
  logic o_free, p_free, b_free, in_take, b_move, b_prod;

  always_comb begin
    o_free   = !out_valid || !out_stall;
    p_free   = !p_valid || o_free;
    b_free   = !b_valid || p_free;
    in_stall = !b_free;
    in_take  = in_valid && b_free;
    b_move   = b_valid && p_free;
  end

  // position of the arriving pixel
  logic [COL_W-1:0] col_pos, col_pos_next, c_cur, c_start;
  logic [ROW_W-1:0] row_pos, row_pos_next, r_cur, r_start;
  logic [HGT_W-1:0] r_wrap, r_inc;
  logic [WCMP-1:0]  c_inc;
  logic             cur_prod, cur_fend;

  always_comb begin
    c_start = frame_start ? '0 : col_pos;
    r_start = frame_start ? '0 : row_pos;
    c_cur   = c_start;
    r_wrap  = HGT_W'(r_start);
    if (WCMP'(c_start) >= w_use) begin
      c_cur  = '0;
      r_wrap = HGT_W'(r_start) + HGT_W'(1);
    end
    r_cur = (r_wrap >= h_use) ? '0 : r_wrap[ROW_W-1:0];

    c_inc        = WCMP'(c_cur) + WCMP'(1);
    r_inc        = HGT_W'(r_cur) + HGT_W'(1);
    col_pos_next = c_inc[COL_W-1:0];
    row_pos_next = r_cur;
    if (c_inc >= w_use) begin
      col_pos_next = '0;
      row_pos_next = (r_inc >= h_use) ? '0 : r_inc[ROW_W-1:0];
    end

    cur_prod = (r_cur >= ROW_W'(2)) && (c_cur >= COL_W'(2));
    cur_fend = (HGT_W'(r_cur) == h_use - HGT_W'(1))
            && (WCMP'(c_cur) == w_use - WCMP'(1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_pos <= '0;
      row_pos <= '0;
    end else if (in_take) begin
      col_pos <= col_pos_next;
      row_pos <= row_pos_next;
    end
  end

  // stage B: pixel plus line store read
  pixel_t             b_px;
  logic [COL_W-1:0]   b_col;
  logic [ROW_W-1:0]   b_row;
  logic               b_fend;
  pixel_t             top_px, mid_px;
  logic [2*PIX_W-1:0] line_rd;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (in_take) begin
      b_valid <= 1'b1;
    end else if (b_move) begin
      b_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      b_px   <= {red_in, green_in, blue_in};
      b_col  <= c_cur;
      b_row  <= r_cur;
      b_prod <= cur_prod;
      b_fend <= cur_fend;
    end
  end

  rgbc_line_store #(
    .DEPTH (MAX_WIDTH)
  ) u_lines (
    .clk     (clk),
    .rd_en   (in_take),
    .rd_addr (c_cur),
    .wr_en   (b_move),
    .wr_addr (b_col),
    .wr_data ({mid_px, b_px}),
    .rd_data (line_rd)
  );

  assign top_px = line_rd[2*PIX_W-1:PIX_W];
  assign mid_px = line_rd[PIX_W-1:0];

  // two previous columns of the window; index 0 is the older
  pixel_t win_top [2];
  pixel_t win_mid [2];
  pixel_t win_bot [2];

  always_ff @(posedge clk) begin
    if (rst) begin
      win_top[0] <= '0;
      win_mid[0] <= '0;
      win_bot[0] <= '0;
      win_top[1] <= '0;
      win_mid[1] <= '0;
      win_bot[1] <= '0;
    end else if (b_move) begin
      win_top[0] <= win_top[1];
      win_mid[0] <= win_mid[1];
      win_bot[0] <= win_bot[1];
      win_top[1] <= top_px;
      win_mid[1] <= mid_px;
      win_bot[1] <= b_px;
    end
  end

  // stage P: products inside the lanes
  logic             p_load;
  logic [COL_W-1:0] p_col;
  logic [ROW_W-1:0] p_row;
  logic             p_fend;
  chan_t            lane_res [3];

  assign p_load = b_move && b_prod;

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
    end else if (p_free) begin
      p_valid <= p_load;
    end
  end

  always_ff @(posedge clk) begin
    if (p_load) begin
      p_col  <= b_col - COL_W'(1);
      p_row  <= b_row - ROW_W'(1);
      p_fend <= b_fend;
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_lane
    localparam int SH = (2 - i) * CHAN_W;
    chan_t [3:0] corners;
    chan_t [3:0] edges;

    assign corners = {win_top[0][SH +: CHAN_W], top_px[SH +: CHAN_W],
                      win_bot[0][SH +: CHAN_W], b_px[SH +: CHAN_W]};
    assign edges   = {win_top[1][SH +: CHAN_W], win_mid[0][SH +: CHAN_W],
                      mid_px[SH +: CHAN_W],     win_bot[1][SH +: CHAN_W]};

    rgbc_lane u_lane (
      .clk     (clk),
      .load    (p_load),
      .corners (corners),
      .edges   (edges),
      .centre  (win_mid[1][SH +: CHAN_W]),
      .kernel  (kernel),
      .result  (lane_res[i])
    );
  end

  // merge: the lanes' clamped values join the position into one result
  logic o_load;
  assign o_load = p_valid && o_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (o_free) begin
      out_valid <= p_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (o_load) begin
      red_out   <= lane_res[0];
      green_out <= lane_res[1];
      blue_out  <= lane_res[2];
      out_row   <= p_row;
      out_col   <= p_col;
      frame_end <= p_fend;
    end
  end

  // border pixels never leave the block
  a_interior_only : assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_row != '0) && (out_col != '0))
    else $error("result on a border row or column");

  a_col_in_range : assert property (@(posedge clk) disable iff (rst)
    in_take |=> (WCMP'(col_pos) < $past(w_use)))
    else $error("column position past the row width");

  a_prod_reaches_p : assert property (@(posedge clk) disable iff (rst)
    (b_move && b_prod) |=> p_valid)
    else $error("interior pixel lost between window and lanes");

endmodule

// ----- hdl/rgbc_line_store.sv -----
// Two-line store: upper and lower row packed in one 48-bit word per column.
// Registered read with bypass of the write issued in the same cycle. Uses rgbc_pkg.
`timescale 1ns / 1ps

module rgbc_line_store
  import rgbc_pkg::*;
#(
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [2*PIX_W-1:0]       wr_data,
  output logic [2*PIX_W-1:0]       rd_data
);

  logic [2*PIX_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // a column revisited straight away (frame restart) must see the pending write
  always_ff @(posedge clk) begin
    if (rd_en) begin
      if (wr_en && (wr_addr == rd_addr)) begin
        rd_data <= wr_data;
      end else begin
        rd_data <= mem[rd_addr];
      end
    end
  end

endmodule

// ----- hdl/rgbc_lane.sv -----
// One colour channel of the 3x3 kernel: tap sums, registered products, clamp.
// Uses rgbc_pkg.
`timescale 1ns / 1ps

module rgbc_lane
  import rgbc_pkg::*;
(
  input  logic               clk,
  input  logic               load,
  input  chan_t [3:0]        corners,
  input  chan_t [3:0]        edges,
  input  chan_t              centre,
  input  kernel_t            kernel,
  output chan_t              result
);

  logic [TAP_SUM_W-1:0] corner_sum;
  logic [TAP_SUM_W-1:0] edge_sum;
  prod_t                corner_prod;
  prod_t                edge_prod;
  prod_t                centre_prod;
  acc_t                 total;

  always_comb begin
    corner_sum = TAP_SUM_W'(corners[0]) + TAP_SUM_W'(corners[1])
               + TAP_SUM_W'(corners[2]) + TAP_SUM_W'(corners[3]);
    edge_sum   = TAP_SUM_W'(edges[0]) + TAP_SUM_W'(edges[1])
               + TAP_SUM_W'(edges[2]) + TAP_SUM_W'(edges[3]);
  end

  always_ff @(posedge clk) begin
    if (load) begin
      corner_prod <= kernel.corner * $signed({1'b0, corner_sum});
      edge_prod   <= kernel.side * $signed({1'b0, edge_sum});
      centre_prod <= kernel.centre * $signed({3'b000, centre});
    end
  end

  always_comb begin
    total = ACC_W'(corner_prod) + ACC_W'(edge_prod) + ACC_W'(centre_prod);
    if (total < 0) begin
      result = '0;
    end else if (total > ACC_W'(CHAN_MAX)) begin
      result = chan_t'(CHAN_MAX);
    end else begin
      result = total[CHAN_W-1:0];
    end
  end

endmodule
